FILE: src/hst_pkg.sv
// Shared types, codes and microcode ROM for the hop slot timer.
// Used by hst_core, hop_slot_timer_unit and hst_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hst_pkg;

  localparam int REQ_W   = 3;
  localparam int TIME_W  = 64;
  localparam int SLOT_W  = 32;
  localparam int TOUT_W  = 63;
  localparam int ST_W    = 3;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 8;
  localparam int S_DATA_W = 96;  // time_us + slot_num
  localparam int M_DATA_W = 96;  // slot_out + time_out, one pad bit

  localparam logic [31:0] SLOT_LEN_RST = 32'd1000;
  localparam logic [31:0] GUARD_RST    = 32'd0;
  localparam logic [31:0] SLOT_MAX     = 32'hFFFF_FFFF;

  localparam logic [CIDX_W-1:0] REG_SLOT_LEN = 8'd0;
  localparam logic [CIDX_W-1:0] REG_GUARD    = 8'd1;

  localparam logic [REQ_W-1:0] REQ_SET        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SLOT_AT    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SLOT_START = 3'd3;
  localparam logic [REQ_W-1:0] REQ_NEXT       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_ARG  = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_CFG  = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_SYNC  = 3'd3;
  localparam logic [ST_W-1:0] ST_BEFORE   = 3'd4;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd5;

  // micro-ops
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_CHECK     = 4'd1;
  localparam logic [3:0] OP_DIV_INIT  = 4'd2;
  localparam logic [3:0] OP_DIV_STEP  = 4'd3;
  localparam logic [3:0] OP_SLOT_ADD  = 4'd4;
  localparam logic [3:0] OP_MUL_INIT  = 4'd5;
  localparam logic [3:0] OP_MUL_STEP  = 4'd6;
  localparam logic [3:0] OP_START_ADD = 4'd7;
  localparam logic [3:0] OP_GUARD     = 4'd8;
  localparam logic [3:0] OP_EMIT      = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NONE  = 3'd0;
  localparam logic [2:0] C_LOOP  = 3'd1;  // count not exhausted
  localparam logic [2:0] C_EARLY = 3'd2;  // error, or set/clear request
  localparam logic [2:0] C_REQ3  = 3'd3;  // slot start request
  localparam logic [2:0] C_NOT4  = 3'd4;  // error, or not next-switch

  localparam logic [3:0] PC_DIV  = 4'd4;
  localparam logic [3:0] PC_MUL  = 4'd7;
  localparam logic [3:0] PC_MULS = 4'd8;
  localparam logic [3:0] PC_END  = 4'd12;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] time_us;
    logic [SLOT_W-1:0] slot_num;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_out;
    logic [TOUT_W-1:0] time_out;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] tgt;
  } uword_t;

  function automatic uword_t hst_rom(input logic [3:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_CHECK,     cond: C_NONE,  tgt: PC_END};
      4'd1:    w = '{op: OP_NOP,       cond: C_EARLY, tgt: PC_END};
      4'd2:    w = '{op: OP_NOP,       cond: C_REQ3,  tgt: PC_MUL};
      4'd3:    w = '{op: OP_DIV_INIT,  cond: C_NONE,  tgt: PC_END};
      4'd4:    w = '{op: OP_DIV_STEP,  cond: C_LOOP,  tgt: PC_DIV};
      4'd5:    w = '{op: OP_SLOT_ADD,  cond: C_NONE,  tgt: PC_END};
      4'd6:    w = '{op: OP_NOP,       cond: C_NOT4,  tgt: PC_END};
      4'd7:    w = '{op: OP_MUL_INIT,  cond: C_NONE,  tgt: PC_END};
      4'd8:    w = '{op: OP_MUL_STEP,  cond: C_LOOP,  tgt: PC_MULS};
      4'd9:    w = '{op: OP_START_ADD, cond: C_NONE,  tgt: PC_END};
      4'd10:   w = '{op: OP_NOP,       cond: C_NOT4,  tgt: PC_END};
      4'd11:   w = '{op: OP_GUARD,     cond: C_NONE,  tgt: PC_END};
      default: w = '{op: OP_EMIT,      cond: C_NONE,  tgt: PC_END};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/hst_core.sv
// Microcoded sequencer and datapath of the hop slot timer: anchor state,
// restoring divider and shift-add multiplier. Depends on hst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hst_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire hst_pkg::req_t             req,
  input  wire logic [hst_pkg::CFG_W-1:0] slot_len,
  input  wire logic [hst_pkg::CFG_W-1:0] guard,
  input  wire logic                      cfg_wr,
  input  wire logic                      out_free,
  output hst_pkg::core_stat_t            stat,
  output hst_pkg::res_t                  res
);
  import hst_pkg::*;

  logic                busy;
  logic [3:0]          pc;
  logic [REQ_W-1:0]    req_type;
  logic [TIME_W-1:0]   t;
  logic [SLOT_W-1:0]   s;
  logic [ST_W-1:0]     st;
  logic [SLOT_W-1:0]   slot_res;
  logic [TOUT_W-1:0]   time_res;
  logic [31:0]         rem;
  logic [63:0]         quo;
  logic [63:0]         acc;
  logic [63:0]         mcand;
  logic [31:0]         mplier;
  logic [5:0]          cnt;
  logic [SLOT_W-1:0]   anchor_slot;
  logic [TOUT_W-1:0]   anchor_time;
  logic                in_sync;

  uword_t              uw;
  logic                take;
  logic                stall;
  logic                cfg_ok;
  logic [ST_W-1:0]     chk_st;
  logic                do_set;
  logic                do_drop;
  logic [33:0]         div_diff;
  logic                div_ge;
  logic [32:0]         slot_sum;
  logic                slot_ovf;
  logic [64:0]         start_sum;
  logic [63:0]         mul_add;

  assign uw       = hst_rom(pc);
  assign cfg_ok   = (slot_len != '0) && (guard < slot_len);
  assign div_diff = {1'b0, rem, quo[63]} - {2'b00, slot_len};
  assign div_ge   = ~div_diff[33];
  assign slot_sum = {1'b0, quo[31:0]} + {1'b0, anchor_slot}
                    + {32'd0, (req_type == REQ_NEXT)};
  assign slot_ovf = (|quo[63:32]) | slot_sum[32];
  assign start_sum = {1'b0, acc} + {2'b00, anchor_time};
  assign mul_add  = acc + mcand;

  always_comb begin
    chk_st  = ST_OK;
    do_set  = 1'b0;
    do_drop = 1'b0;
    if (!(req_type inside {REQ_SET, REQ_CLEAR, REQ_SLOT_AT, REQ_SLOT_START, REQ_NEXT})) begin
      chk_st = ST_BAD_ARG;
    end else if (!cfg_ok) begin
      chk_st = ST_BAD_CFG;
    end else if (req_type == REQ_SET) begin
      if (t[63]) chk_st = ST_BAD_ARG;
      else       do_set = 1'b1;
    end else if (req_type == REQ_CLEAR) begin
      do_drop = 1'b1;
    end else if (!in_sync) begin
      chk_st = ST_NO_SYNC;
    end else if (req_type == REQ_SLOT_START) begin
      if (s < anchor_slot) chk_st = ST_BEFORE;
    end else if (t[63] || (t[62:0] < anchor_time)) begin
      chk_st = ST_BEFORE;
    end
  end

  always_comb begin
    case (uw.cond)
      C_LOOP:  take = (cnt != '0);
      C_EARLY: take = (st != ST_OK) || (req_type == REQ_SET) || (req_type == REQ_CLEAR);
      C_REQ3:  take = (req_type == REQ_SLOT_START);
      C_NOT4:  take = (st != ST_OK) || (req_type != REQ_NEXT);
      default: take = 1'b0;
    endcase
  end

  assign stall     = (uw.op == OP_EMIT) && !out_free;
  assign stat.busy = busy;
  assign stat.done = busy && (uw.op == OP_EMIT) && out_free;

  always_comb begin
    res.status   = st;
    res.slot_out = (st == ST_OK) ? slot_res : '0;
    res.time_out = (st == ST_OK) ? time_res : '0;
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (uw.op == OP_EMIT) begin
      if (!stall) busy <= 1'b0;
    end else begin
      pc <= take ? uw.tgt : pc + 4'd1;
    end
  end

  // anchor state
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_slot <= '0;
      anchor_time <= '0;
      in_sync     <= 1'b0;
    end else if (cfg_wr || (busy && uw.op == OP_CHECK && do_drop)) begin
      anchor_slot <= '0;
      anchor_time <= '0;
      in_sync     <= 1'b0;
    end else if (busy && uw.op == OP_CHECK && do_set) begin
      anchor_slot <= s;
      anchor_time <= t[62:0];
      in_sync     <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        req_type <= req.req_type;
        t        <= req.time_us;
        s        <= req.slot_num;
        st       <= ST_OK;
        slot_res <= '0;
        time_res <= '0;
      end
    end else begin
      case (uw.op)
        OP_CHECK: st <= chk_st;
        OP_DIV_INIT: begin
          rem <= '0;
          quo <= t - {1'b0, anchor_time};
          cnt <= 6'd63;
        end
        OP_DIV_STEP: begin
          rem <= div_ge ? div_diff[31:0] : {rem[30:0], quo[63]};
          quo <= {quo[62:0], div_ge};
          cnt <= cnt - 6'd1;
        end
        OP_SLOT_ADD: begin
          if (slot_ovf) begin
            st <= ST_OVERFLOW;
          end else begin
            slot_res <= slot_sum[31:0];
            s        <= slot_sum[31:0];
          end
        end
        OP_MUL_INIT: begin
          acc    <= '0;
          mcand  <= {32'd0, slot_len};
          mplier <= s - anchor_slot;
          cnt    <= 6'd31;
        end
        OP_MUL_STEP: begin
          if (mplier[0]) acc <= mul_add;
          mcand  <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[31:1]};
          cnt    <= cnt - 6'd1;
        end
        OP_START_ADD: begin
          if (|start_sum[64:63]) st <= ST_OVERFLOW;
          else                   time_res <= start_sum[62:0];
        end
        OP_GUARD: time_res <= time_res - {31'd0, guard};
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/hop_slot_timer_unit.sv
// Sequence, accept to tvalid: set, clear and every check-stage error end after
// the check; slot-at-time runs the divider, slot-start the multiplier, next-switch
// both (divider only on slot overflow). One word at a time: the next word is
// accepted only once the result has moved to the output register, and a full
// output register holds the core. The divider takes 64 steps, the multiplier 32.
// Reset: synchronous; clears anchor and sync, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module hop_slot_timer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [hst_pkg::S_DATA_W-1:0] s_tdata,  // time_us, slot_num
  input  wire logic [hst_pkg::REQ_W-1:0]    s_tuser,  // req_type
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [hst_pkg::M_DATA_W-1:0]      m_tdata,  // slot_out, time_out, pad
  output logic [hst_pkg::ST_W-1:0]          m_tuser,  // status
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hst_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [hst_pkg::CFG_W-1:0]    cfg_data
);
  import hst_pkg::*;

  logic [CFG_W-1:0] slot_len;
  logic [CFG_W-1:0] guard;
  logic             cfg_wr;
  logic             out_free;
  req_t             req;
  res_t             res;
  core_stat_t       stat;

  assign s_tready  = ~stat.busy;
  assign cfg_ready = ~stat.busy;
  assign cfg_wr    = cfg_valid & cfg_ready
                     & ((cfg_index == REG_SLOT_LEN) | (cfg_index == REG_GUARD));
  assign out_free  = ~m_tvalid | m_tready;

  assign req.req_type = s_tuser;
  assign req.time_us  = s_tdata[63:0];
  assign req.slot_num = s_tdata[95:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_len <= SLOT_LEN_RST;
      guard    <= GUARD_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SLOT_LEN) slot_len <= cfg_data;
      if (cfg_index == REG_GUARD)    guard    <= cfg_data;
    end
  end

  hst_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid & s_tready),
    .req      (req),
    .slot_len (slot_len),
    .guard    (guard),
    .cfg_wr   (cfg_wr),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      m_tuser <= res.status;
      m_tdata <= {1'b0, res.time_out, res.slot_out};
    end
  end

endmodule

`default_nettype wire

FILE: src/hst_checker.sv
// Port-level assertions for hop_slot_timer_unit, bound to the top level.
// Depends on hst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hst_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [hst_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [hst_pkg::ST_W-1:0]     m_tuser,
  input wire logic                         cfg_ready
);
  import hst_pkg::*;

  // one word in flight: no new word right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BAD_ARG || m_tuser == ST_BAD_CFG ||
                  m_tuser == ST_NO_SYNC || m_tuser == ST_BEFORE || m_tuser == ST_OVERFLOW))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error word carries data");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[M_DATA_W-1])
    else $error("pad bit set");

endmodule

bind hop_slot_timer_unit hst_checker u_chk (.*);

`default_nettype wire
